FILE: hdl/arp_cache_engine_unit_macros.svh
// Assertion macros for the ARP cache engine.
// ARP_ASSERT is disabled while reset is asserted; ARP_ASSERT_NORST checks at every edge.
`ifndef ARP_CACHE_ENGINE_UNIT_MACROS_SVH
`define ARP_CACHE_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTH
`define ARP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ARP_ASSERT_NORST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARP_ASSERT(label, prop, msg)
`define ARP_ASSERT_NORST(label, prop, msg)
`endif

`endif

FILE: hdl/arp_pkg.sv
`default_nettype none

package arp_pkg;

	// table depth, one cell per entry
	localparam int TABLE_ENTRIES = 16;

	// configuration register map (64-bit registers at 8-byte spacing)
	localparam int ADDR_W = 5;
	localparam logic [1:0] REG_OWN_IP_ASSIGNED = 2'd0;
	localparam logic [1:0] REG_BROADCAST_IP    = 2'd1;
	localparam logic [1:0] REG_BROADCAST_MAC   = 2'd2;

	// item kinds and received opcodes
	localparam logic        KIND_PACKET = 1'b0;
	localparam logic        KIND_LOOKUP = 1'b1;
	localparam logic [15:0] OP_REQUEST  = 16'd1;
	localparam logic [15:0] OP_REPLY    = 16'd2;

	// transmit opcodes
	localparam logic [1:0] SEND_NONE    = 2'd0;
	localparam logic [1:0] SEND_REQUEST = 2'd1;
	localparam logic [1:0] SEND_REPLY   = 2'd2;

	// result status codes
	localparam logic [3:0] ST_LEARNED    = 4'd0;
	localparam logic [3:0] ST_FULL       = 4'd1;
	localparam logic [3:0] ST_REPLY      = 4'd2;
	localparam logic [3:0] ST_REPLY_SUPP = 4'd3;
	localparam logic [3:0] ST_HIT        = 4'd4;
	localparam logic [3:0] ST_BCAST      = 4'd5;
	localparam logic [3:0] ST_MISS_REQ   = 4'd6;
	localparam logic [3:0] ST_MISS_NOIP  = 4'd7;
	localparam logic [3:0] ST_IGNORED    = 4'd8;

	typedef struct packed {
		logic        kind;
		logic [15:0] op_code;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] query_ip;
	} arp_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [47:0] found_mac;
		logic        send_valid;
		logic [1:0]  send_opcode;
		logic [47:0] send_target_mac;
		logic [31:0] send_target_ip;
	} arp_result_t;

	// probe token walking the row of cells
	typedef struct packed {
		logic        vld;
		logic        claim;     // second pass: first free cell takes the entry
		logic        learn;     // first pass of a received reply: refresh a match
		logic [31:0] ip;
		logic [47:0] mac;
		logic        hit;       // match found, or entry claimed
		logic        free_seen; // a free cell was passed
		logic [47:0] found_mac;
	} arp_probe_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAUNCH,
		S_SCAN,
		S_CLAIM_LAUNCH,
		S_CLAIM,
		S_FINISH
	} arp_state_t;

endpackage

`default_nettype wire

FILE: hdl/arp_cell.sv
`default_nettype none

// One table entry plus one stage of the probe path.
module arp_cell import arp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire arp_probe_t probe_in,
	output arp_probe_t      probe_out
);

	logic        present_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic        vld_q;
	arp_probe_t  probe_q;
	logic        match;
	logic        take;
	arp_probe_t  probe_d;

	// compare against this entry; claim if free and not yet claimed
	assign match = probe_in.vld && !probe_in.claim && present_q && (ip_q == probe_in.ip);
	assign take  = probe_in.vld && probe_in.claim && !present_q && !probe_in.hit;

	always_comb begin
		probe_d = probe_in;
		if (match) begin
			probe_d.hit = 1'b1;
			if (!probe_in.learn) begin
				probe_d.found_mac = mac_q;
			end
		end
		if (!present_q && !probe_in.claim) begin
			probe_d.free_seen = 1'b1;
		end
		if (take) begin
			probe_d.hit = 1'b1;
		end
	end

	// entry present bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
		end else if (take) begin
			present_q <= 1'b1;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (take) begin
			ip_q  <= probe_in.ip;
			mac_q <= probe_in.mac;
		end else if (match && probe_in.learn) begin
			mac_q <= probe_in.mac;
		end
	end

	// probe stage: valid under reset, payload free-running
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= probe_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		probe_q <= probe_d;
	end

	always_comb begin
		probe_out     = probe_q;
		probe_out.vld = vld_q;
	end

endmodule

`default_nettype wire

FILE: hdl/arp_cache_engine_unit.sv
`default_nettype none

// ARP cache engine: a table of TABLE_ENTRIES entries held in a row of cells, one entry per
// cell, searched by a probe that moves one cell per clock. Each item (received packet or
// lookup) is handled alone and gives one result; the next item is accepted only after the
// probe's walk along the row. A received reply from an unknown IP that takes a free entry
// walks the row twice, once to search for a match and once to claim the first free cell.
// A finished result waits in the output register, and the next item is taken meanwhile.
// Registers over the APB port (64-bit, 8-byte spacing): 0x00 own_ip_assigned,
// 0x08 broadcast_ip, 0x10 broadcast_mac; write them only while the engine is idle.
module arp_cache_engine_unit import arp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire arp_item_t         item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output arp_result_t            result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [63:0]       pwdata,
	output logic [63:0]            prdata,
	output logic                   pready
);

	arp_state_t  state_q, state_d;
	arp_item_t   item_q;
	arp_probe_t  tail_q;
	arp_result_t result_q, result_d;
	logic        result_valid_q;
	logic        own_ip_q;
	logic [31:0] bcast_ip_q;
	logic [47:0] bcast_mac_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;
	logic        inject, inject_claim, load_result, learn_item;
	arp_probe_t  head;
	arp_probe_t  chain [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES:0] probe_vld;
	arp_probe_t  tail;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q    <= 1'b0;
			bcast_ip_q  <= 32'hFFFF_FFFF;
			bcast_mac_q <= 48'hFFFF_FFFF_FFFF;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_OWN_IP_ASSIGNED: own_ip_q    <= pwdata[0];
				REG_BROADCAST_IP:    bcast_ip_q  <= pwdata[31:0];
				REG_BROADCAST_MAC:   bcast_mac_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_OWN_IP_ASSIGNED: prdata = {63'd0, own_ip_q};
			REG_BROADCAST_IP:    prdata = {32'd0, bcast_ip_q};
			REG_BROADCAST_MAC:   prdata = {16'd0, bcast_mac_q};
			default:             prdata = 64'd0;
		endcase
	end

	// probe injection into the first cell
	assign learn_item = (item_q.kind == KIND_PACKET) && (item_q.op_code == OP_REPLY);

	always_comb begin
		head       = '0;
		head.vld   = inject || inject_claim;
		head.claim = inject_claim;
		head.learn = learn_item;
		head.ip    = (item_q.kind == KIND_LOOKUP) ? item_q.query_ip : item_q.sender_ip;
		head.mac   = item_q.sender_mac;
	end

	assign chain[0] = head;

	// row of cells
	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			arp_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.probe_in  (chain[g]),
				.probe_out (chain[g+1])
			);
		end
		for (g = 0; g <= TABLE_ENTRIES; g++) begin : g_vld
			assign probe_vld[g] = chain[g].vld;
		end
	endgenerate

	assign tail = chain[TABLE_ENTRIES];

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:         if (item_valid) state_d = S_LAUNCH;
			S_LAUNCH:       state_d = S_SCAN;
			S_SCAN: begin
				if (tail.vld) begin
					state_d = (learn_item && !tail.hit && tail.free_seen) ?
						S_CLAIM_LAUNCH : S_FINISH;
				end
			end
			S_CLAIM_LAUNCH: state_d = S_CLAIM;
			S_CLAIM:        if (tail.vld) state_d = S_FINISH;
			S_FINISH:       if (!result_valid_q || result_ready) state_d = S_IDLE;
			default:        state_d = S_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		item_ready   = 1'b0;
		inject       = 1'b0;
		inject_claim = 1'b0;
		load_result  = 1'b0;
		unique case (state_q)
			S_IDLE:         item_ready   = 1'b1;
			S_LAUNCH:       inject       = 1'b1;
			S_CLAIM_LAUNCH: inject_claim = 1'b1;
			S_FINISH:       load_result  = !result_valid_q || result_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// captured item and probe at the end of the row
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		if (tail.vld) begin
			tail_q <= tail;
		end
	end

	// result formation
	always_comb begin
		result_d        = '0;
		result_d.status = ST_IGNORED;
		if (item_q.kind == KIND_PACKET) begin
			if (item_q.op_code == OP_REQUEST) begin
				if (own_ip_q) begin
					result_d.status          = ST_REPLY;
					result_d.send_valid      = 1'b1;
					result_d.send_opcode     = SEND_REPLY;
					result_d.send_target_mac = item_q.sender_mac;
					result_d.send_target_ip  = item_q.sender_ip;
				end else begin
					result_d.status = ST_REPLY_SUPP;
				end
			end else if (item_q.op_code == OP_REPLY) begin
				result_d.status = tail_q.hit ? ST_LEARNED : ST_FULL;
			end
		end else if (item_q.query_ip == bcast_ip_q) begin
			result_d.status    = ST_BCAST;
			result_d.found_mac = bcast_mac_q;
		end else if (tail_q.hit) begin
			result_d.status    = ST_HIT;
			result_d.found_mac = tail_q.found_mac;
		end else if (own_ip_q) begin
			result_d.status          = ST_MISS_REQ;
			result_d.send_valid      = 1'b1;
			result_d.send_opcode     = SEND_REQUEST;
			result_d.send_target_mac = bcast_mac_q;
			result_d.send_target_ip  = item_q.query_ip;
		end else begin
			result_d.status = ST_MISS_NOIP;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`include "arp_cache_engine_unit_macros.svh"

	`ARP_ASSERT(a_single_probe, $onehot0(probe_vld), "more than one probe in the row")
	`ARP_ASSERT(a_probe_in_scan, (|probe_vld[TABLE_ENTRIES:1]) |-> (state_q == S_SCAN || state_q == S_CLAIM), "probe in the row outside a scan")
	`ARP_ASSERT(a_scan_exit, (state_q == S_SCAN && tail.vld) |=> (state_q == S_FINISH || state_q == S_CLAIM_LAUNCH), "scan did not end on probe arrival")
	`ARP_ASSERT(a_claim_taken, (state_q == S_CLAIM && tail.vld) |-> tail.hit, "claim pass found no free entry")
	`ARP_ASSERT(a_learned_only_reply, (load_result && result_d.status == ST_LEARNED) |-> learn_item, "learned status for an item that is not a reply")

endmodule

`default_nettype wire
